/* hw/rtl/sce_pkg.sv */
package sce_pkg;

  // Channel count and derived widths
  localparam int CHANNELS     = 12;
  localparam int CH_IDX_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int MASK_W       = 12;
  localparam int SAMPLE_COUNT = 128;

  // Envelope limits
  localparam logic [7:0]  LEVEL_MAX   = 8'd128;
  localparam logic [7:0]  LEVEL_STEP  = 8'd16;
  localparam logic [21:0] PERIOD_STEP = 22'(50 * 256);
  localparam logic [21:0] PERIOD_MIN  = 22'(50 * 256);
  localparam logic [21:0] PERIOD_MAX  = 22'(4096 * 256);

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_TICK  = 2'd1,
    ACT_STOP  = 2'd2
  } sce_act_t;

  typedef enum logic [2:0] {
    CMD_PLAY     = 3'd0,
    CMD_SET_VOL  = 3'd1,
    CMD_SET_PER  = 3'd2,
    CMD_HALT     = 3'd3,
    CMD_HALT_ALL = 3'd4
  } sce_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_CALC,
    ST_EMIT_A,
    ST_EMIT_B,
    ST_FLUSH
  } sce_state_t;

  typedef struct packed {
    logic [1:0]         action;
    logic [11:0]        playing_mask;
    logic [11:0]        exhausted_mask;
    logic [7:0]         effect_id;
    logic               sample_loaded;
    logic [6:0]         volume;
    logic [12:0]        period;
    logic               looping;
    logic [7:0]         duration;
    logic signed [7:0]  vol_step;
    logic signed [7:0]  pitch_step;
  } sce_req_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [3:0]  channel;
    logic [6:0]  play_id;
    logic [7:0]  level;
    logic [20:0] period_scaled;
    logic        loop_play;
    logic        resample_mode;
    logic        last;
  } sce_res_t;

  // One channel entry in the envelope memory
  typedef struct packed {
    logic [7:0]  ticks_left;
    logic [7:0]  level;
    logic [7:0]  vol_step;
    logic [7:0]  vol_count;
    logic [7:0]  pitch_step;
    logic [7:0]  pitch_count;
    logic [20:0] period;
  } sce_entry_t;

  // Outcome of one tick on one channel
  typedef struct packed {
    sce_entry_t  entry;
    logic        release_ch;
    logic        vol_v;
    logic [7:0]  vol_level;
    logic        b_v;
    logic        b_halt;
    logic [20:0] b_period;
  } sce_upd_t;

  // Magnitude of a signed 8-bit step, -128 gives 128
  function automatic logic [7:0] mag8(input logic [7:0] raw);
    return raw[7] ? ((~raw) + 8'd1) : raw;
  endfunction

  // Mask bits per channel; channels beyond the mask width read as zero
  function automatic logic [CHANNELS-1:0] chan_mask(input logic [MASK_W-1:0] m);
    logic [CHANNELS-1:0] res;
    res = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (i < MASK_W) res[i] = m[i];
    end
    return res;
  endfunction

  // First channel not playing, channel 0 when all are busy
  function automatic logic [CH_IDX_W-1:0] first_free(input logic [CHANNELS-1:0] pm);
    logic [CH_IDX_W-1:0] sel;
    sel = '0;
    for (int i = CHANNELS - 1; i >= 0; i--) begin
      if (!pm[i]) sel = CH_IDX_W'(i);
    end
    return sel;
  endfunction

endpackage

/* hw/rtl/sce_if.sv */
interface sce_req_if import sce_pkg::*; ();
  logic     valid;
  logic     ready;
  sce_req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface sce_res_if import sce_pkg::*; ();
  logic     valid;
  logic     ready;
  sce_res_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/sce_chan_ram.sv */
module sce_chan_ram import sce_pkg::*; (
  input  logic                clk,
  input  logic                we,
  input  logic [CH_IDX_W-1:0] waddr,
  input  sce_entry_t          wdata,
  input  logic                re,
  input  logic [CH_IDX_W-1:0] raddr,
  output sce_entry_t          rdata
);

  sce_entry_t mem [CHANNELS];
  sce_entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (re) rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/sce_env_step.sv */
module sce_env_step import sce_pkg::*; (
  input  sce_entry_t entry,
  input  logic       playing,
  input  logic       exhausted,
  output sce_upd_t   upd
);

  logic        dur_halt;
  logic [7:0]  lv;
  logic [21:0] p;

  always_comb begin
    upd          = '0;
    upd.entry    = entry;
    dur_halt     = 1'b0;
    lv           = entry.level;
    p            = {1'b0, entry.period};
    if (!playing) begin
      upd.release_ch = 1'b1;
    end else begin
      if (entry.ticks_left != 8'd0) begin
        upd.entry.ticks_left = entry.ticks_left - 8'd1;
        if (entry.ticks_left == 8'd1) begin
          dur_halt       = 1'b1;
          upd.b_v        = 1'b1;
          upd.b_halt     = 1'b1;
          upd.release_ch = 1'b1;
        end
      end
      if (!dur_halt) begin
        // volume ramp holds at either bound
        if (entry.vol_step != 8'd0 && entry.level != 8'd0 && entry.level < LEVEL_MAX) begin
          if (entry.vol_count == 8'd0) begin
            upd.entry.vol_count = mag8(entry.vol_step) - 8'd1;
            if (entry.vol_step[7]) begin
              lv = (entry.level > LEVEL_STEP) ? entry.level - LEVEL_STEP : 8'd0;
            end else begin
              lv = entry.level + LEVEL_STEP;
              if (lv > LEVEL_MAX) lv = LEVEL_MAX;
            end
            upd.entry.level = lv;
            upd.vol_v       = 1'b1;
            upd.vol_level   = lv;
          end else begin
            upd.entry.vol_count = entry.vol_count - 8'd1;
          end
        end
        if (entry.pitch_step != 8'd0) begin
          if (exhausted) begin
            upd.b_v        = 1'b1;
            upd.b_halt     = 1'b1;
            upd.release_ch = 1'b1;
          end else if (entry.pitch_count == 8'd0) begin
            upd.entry.pitch_count = mag8(entry.pitch_step) - 8'd1;
            if (entry.pitch_step[7]) begin
              p = (p > PERIOD_STEP) ? p - PERIOD_STEP : 22'd0;
            end else begin
              p = p + PERIOD_STEP;
            end
            if (p < PERIOD_MIN) p = PERIOD_MIN;
            if (p > PERIOD_MAX) p = PERIOD_MAX;
            upd.entry.period = p[20:0];
            upd.b_v          = 1'b1;
            upd.b_period     = p[20:0];
          end else begin
            upd.entry.pitch_count = entry.pitch_count - 8'd1;
          end
        end
      end
    end
  end

endmodule

/* hw/rtl/sound_channel_envelope_engine_core.sv */
// Sound-effect envelope engine for twelve mixer channels. Three kinds of request come in:
// start, a 50 Hz tick, and stop-all. A start takes the first channel the mixer is not
// playing (channel 0 if all are busy), loads its envelope and gives one play command; a
// sample id out of range or not loaded gives nothing. Stop-all gives one halt-all command.
// A tick walks the channels in order and may give set-volume, set-period and halt
// commands; the final command of every request has last set. Envelope state sits in a
// twelve-entry memory with a registered read; the active flags are flip-flops.
// A start or stop puts its command in the hold register and moves it to the output register
// in the flush state. A tick walks every channel: for each active one it reads the memory,
// then updates and writes the entry back and emits any commands raised; the walk closes in
// the flush state. Requests are taken one at a time; a finished command may wait at the
// output while the next request is accepted.
module sound_channel_envelope_engine_core import sce_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  sce_req_if.sink      in_if,
  sce_res_if.source    out_if
);

  sce_state_t          state_r, state_nxt;
  logic [CH_IDX_W-1:0] c_r;
  logic [CHANNELS-1:0] active_r;
  logic [MASK_W-1:0]   playing_r, exh_r;

  // one command held back so last can be set when the request closes
  logic                held_v_r;
  sce_res_t            held_r;
  logic                out_v_r;
  sce_res_t            out_r;
  sce_res_t            pend_a_r, pend_b_r;
  logic                pend_b_v_r;

  logic                out_free, can_gen, gen_en, gen_fire, flush, adv;
  logic                in_acc, start_ok, c_last;
  sce_res_t            gen_res, flush_res, play_res, stop_res, a_res, b_res;

  logic                we, re;
  logic [CH_IDX_W-1:0] waddr, free_ch;
  sce_entry_t          wdata, start_entry, rdata;
  logic [CHANNELS-1:0] pl_vec, ex_vec;
  sce_upd_t            upd;
  logic [8:0]          id_ext;
  logic [7:0]          vol2;

  sce_chan_ram u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (c_r),
    .rdata (rdata)
  );

  assign pl_vec = chan_mask(playing_r);
  assign ex_vec = chan_mask(exh_r);

  sce_env_step u_step (
    .entry     (rdata),
    .playing   (pl_vec[c_r]),
    .exhausted (ex_vec[c_r]),
    .upd       (upd)
  );

  assign out_free = !out_v_r || out_if.ready;
  assign can_gen  = !held_v_r || out_free;
  assign gen_fire = gen_en && can_gen;
  assign in_acc   = in_if.valid && in_if.ready;
  assign c_last   = (c_r == CH_IDX_W'(CHANNELS - 1));

  assign in_if.ready  = (state_r == ST_IDLE);
  assign out_if.valid = out_v_r;
  assign out_if.data  = out_r;

  // Start request: channel pick, envelope load and play command
  always_comb begin
    id_ext   = {1'b0, in_if.data.effect_id};
    start_ok = (id_ext < 9'(SAMPLE_COUNT)) && in_if.data.sample_loaded;
    free_ch  = first_free(chan_mask(in_if.data.playing_mask));
    vol2     = {in_if.data.volume, 1'b0};
    if (vol2 > LEVEL_MAX) vol2 = LEVEL_MAX;

    start_entry.ticks_left  = in_if.data.looping ? 8'd0 : in_if.data.duration;
    start_entry.level       = vol2;
    start_entry.vol_step    = in_if.data.vol_step;
    start_entry.vol_count   = mag8(in_if.data.vol_step);
    start_entry.pitch_step  = in_if.data.pitch_step;
    start_entry.pitch_count = mag8(in_if.data.pitch_step);
    start_entry.period      = {in_if.data.period, 8'd0};

    play_res               = '0;
    play_res.command       = CMD_PLAY;
    play_res.channel       = 4'(free_ch);
    play_res.play_id       = in_if.data.effect_id[6:0];
    play_res.level         = vol2;
    play_res.period_scaled = {in_if.data.period, 8'd0};
    play_res.resample_mode = (in_if.data.pitch_step != 8'sd0);
    play_res.loop_play     = play_res.resample_mode || in_if.data.looping;

    stop_res         = '0;
    stop_res.command = CMD_HALT_ALL;
  end

  // Per-channel tick commands
  always_comb begin
    a_res         = '0;
    a_res.command = CMD_SET_VOL;
    a_res.channel = 4'(c_r);
    a_res.level   = upd.vol_level;

    b_res         = '0;
    b_res.channel = 4'(c_r);
    if (upd.b_halt) begin
      b_res.command = CMD_HALT;
    end else begin
      b_res.command       = CMD_SET_PER;
      b_res.period_scaled = upd.b_period;
    end

    flush_res      = held_r;
    flush_res.last = 1'b1;
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    gen_en    = 1'b0;
    gen_res   = play_res;
    flush     = 1'b0;
    adv       = 1'b0;
    we        = 1'b0;
    waddr     = c_r;
    wdata     = upd.entry;
    re        = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_if.valid) begin
          case (in_if.data.action)
            ACT_START: begin
              if (start_ok) begin
                we        = 1'b1;
                waddr     = free_ch;
                wdata     = start_entry;
                gen_en    = 1'b1;
                gen_res   = play_res;
                state_nxt = ST_FLUSH;
              end
            end
            ACT_TICK: state_nxt = ST_RD;
            ACT_STOP: begin
              gen_en    = 1'b1;
              gen_res   = stop_res;
              state_nxt = ST_FLUSH;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_RD: begin
        if (active_r[c_r]) begin
          re        = 1'b1;
          state_nxt = ST_CALC;
        end else begin
          adv = 1'b1;
        end
      end
      ST_CALC: begin
        // write-back lands before any later read of this entry
        we = 1'b1;
        if (upd.vol_v)    state_nxt = ST_EMIT_A;
        else if (upd.b_v) state_nxt = ST_EMIT_B;
        else              adv       = 1'b1;
      end
      ST_EMIT_A: begin
        gen_en  = 1'b1;
        gen_res = pend_a_r;
        if (can_gen) begin
          if (pend_b_v_r) state_nxt = ST_EMIT_B;
          else            adv       = 1'b1;
        end
      end
      ST_EMIT_B: begin
        gen_en  = 1'b1;
        gen_res = pend_b_r;
        if (can_gen) adv = 1'b1;
      end
      ST_FLUSH: begin
        if (!held_v_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          flush     = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (adv) state_nxt = c_last ? ST_FLUSH : ST_RD;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_r      <= '0;
      active_r <= '0;
      held_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (in_acc) c_r <= '0;
      else if (adv) c_r <= c_r + CH_IDX_W'(1);

      if (in_acc && in_if.data.action == ACT_START && start_ok) active_r[free_ch] <= 1'b1;
      if (in_acc && in_if.data.action == ACT_STOP) active_r <= '0;
      if (state_r == ST_CALC && upd.release_ch) active_r[c_r] <= 1'b0;

      if (out_if.ready) out_v_r <= 1'b0;
      if (gen_fire) begin
        if (held_v_r) out_v_r <= 1'b1;
        held_v_r <= 1'b1;
      end
      if (flush) begin
        out_v_r  <= 1'b1;
        held_v_r <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      playing_r <= in_if.data.playing_mask;
      exh_r     <= in_if.data.exhausted_mask;
    end
    if (state_r == ST_CALC) begin
      pend_a_r   <= a_res;
      pend_b_r   <= b_res;
      pend_b_v_r <= upd.b_v;
    end
    if (gen_fire) begin
      if (held_v_r) out_r <= held_r;
      held_r <= gen_res;
    end
    if (flush) out_r <= flush_res;
  end

endmodule

/* dv/tb_sound_channel_envelope_engine_core.sv */
module tb_sound_channel_envelope_engine_core;
  timeunit 1ns;
  timeprecision 1ps;

  import sce_pkg::*;

  // Action code that the block has no meaning for; it must be dropped silently
  localparam logic [1:0] ACT_UNKNOWN = 2'd3;

  localparam int HOLD_CYCLES   = 400;    // long output hold-off
  localparam int DRAIN_LIMIT   = 20000;  // cycles allowed for outstanding commands
  localparam int SETTLE_CYCLES = 60;     // longest tick walk plus margin
  localparam int MAX_SHOWN     = 40;     // mismatch lines printed before going quiet

  logic clk;
  logic rst_n;

  sce_req_if req_ch ();
  sce_res_if res_ch ();

  sound_channel_envelope_engine_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (req_ch),
    .out_if (res_ch)
  );

  // ---------------------------------------------------------------------------
  // Envelope predictor: private copy of the per-channel state
  // ---------------------------------------------------------------------------
  logic [CHANNELS-1:0] ch_busy;
  logic [7:0]          ch_ticks [CHANNELS];
  logic [7:0]          ch_lvl   [CHANNELS];
  logic [7:0]          ch_vstep [CHANNELS];
  logic [7:0]          ch_vcnt  [CHANNELS];
  logic [7:0]          ch_pstep [CHANNELS];
  logic [7:0]          ch_pcnt  [CHANNELS];
  logic [20:0]         ch_per   [CHANNELS];

  sce_res_t pending_cmds [$];  // mixer commands still owed by the block, oldest first
  sce_res_t new_cmds [$];      // commands raised by the request being predicted

  int mismatches;
  int live_requests;  // requests that the block acts on (ignored ones excluded)
  bit idle_on;        // random gaps on both sides
  bit hold_output;    // asks the receiver for one long hold-off

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Magnitude of a signed 8-bit ramp step; -128 gives 128
  function automatic logic [8:0] step_size(input logic [7:0] s);
    return s[7] ? (9'd256 - {1'b0, s}) : {1'b0, s};
  endfunction

  // A released channel: level parks at full scale, all else cleared
  function automatic void clear_channel(input int c);
    ch_busy[c]  = 1'b0;
    ch_ticks[c] = '0;
    ch_lvl[c]   = LEVEL_MAX;
    ch_vstep[c] = '0;
    ch_vcnt[c]  = '0;
    ch_pstep[c] = '0;
    ch_pcnt[c]  = '0;
    ch_per[c]   = '0;
  endfunction

  function automatic void add_command(input sce_cmd_t cmd, input int c,
                                      input logic [6:0] id, input logic [7:0] lvl,
                                      input logic [20:0] per, input bit lp, input bit rs);
    sce_res_t r;
    r.command       = cmd;
    r.channel       = 4'(c);
    r.play_id       = id;
    r.level         = lvl;
    r.period_scaled = per;
    r.loop_play     = lp;
    r.resample_mode = rs;
    r.last          = 1'b0;
    new_cmds.push_back(r);
  endfunction

  // Works out the mixer commands that one accepted request must produce
  function automatic void predict_envelope(input sce_req_t r);
    int          c;
    bit          found;
    logic [7:0]  vol;
    int unsigned lv;
    int unsigned p;
    sce_res_t    tail;
    c = 0;
    found = 1'b0;
    case (r.action)
      ACT_START: begin
        if (r.effect_id < SAMPLE_COUNT && r.sample_loaded) begin
          live_requests++;
          for (int i = 0; i < CHANNELS; i++) begin
            if (!found && !r.playing_mask[i]) begin
              c = i;
              found = 1'b1;
            end
          end
          // doubled volume, saturated at full scale
          vol = {r.volume, 1'b0};
          if (vol > LEVEL_MAX) vol = LEVEL_MAX;
          ch_busy[c]  = 1'b1;
          ch_ticks[c] = r.looping ? 8'd0 : r.duration;
          ch_lvl[c]   = vol;
          ch_vstep[c] = r.vol_step;
          ch_vcnt[c]  = 8'(step_size(r.vol_step));
          ch_pstep[c] = r.pitch_step;
          ch_pcnt[c]  = 8'(step_size(r.pitch_step));
          ch_per[c]   = {r.period, 8'd0};
          add_command(CMD_PLAY, c, r.effect_id[6:0], vol, {r.period, 8'd0},
                      (r.pitch_step != 0) ? 1'b1 : r.looping, r.pitch_step != 0);
        end
      end
      ACT_TICK: begin
        live_requests++;
        for (c = 0; c < CHANNELS; c++) begin
          if (!ch_busy[c]) continue;
          // mixer already done with it: release without a command
          if (!r.playing_mask[c]) begin
            clear_channel(c);
            continue;
          end
          if (ch_ticks[c] != 0) begin
            ch_ticks[c] = ch_ticks[c] - 8'd1;
            if (ch_ticks[c] == 0) begin
              add_command(CMD_HALT, c, '0, '0, '0, 1'b0, 1'b0);
              clear_channel(c);
              continue;
            end
          end
          // volume ramp is frozen at either bound
          if (ch_vstep[c] != 0 && ch_lvl[c] != 0 && ch_lvl[c] < LEVEL_MAX) begin
            if (ch_vcnt[c] == 0) begin
              ch_vcnt[c] = 8'(step_size(ch_vstep[c]) - 9'd1);
              lv = ch_lvl[c];
              if (ch_vstep[c][7]) begin
                lv = (lv > LEVEL_STEP) ? lv - LEVEL_STEP : 0;
              end else begin
                lv = lv + LEVEL_STEP;
                if (lv > LEVEL_MAX) lv = LEVEL_MAX;
              end
              ch_lvl[c] = 8'(lv);
              add_command(CMD_SET_VOL, c, '0, 8'(lv), '0, 1'b0, 1'b0);
            end else begin
              ch_vcnt[c] = ch_vcnt[c] - 8'd1;
            end
          end
          if (ch_pstep[c] != 0) begin
            // resampled data ran out
            if (r.exhausted_mask[c]) begin
              add_command(CMD_HALT, c, '0, '0, '0, 1'b0, 1'b0);
              clear_channel(c);
              continue;
            end
            if (ch_pcnt[c] == 0) begin
              ch_pcnt[c] = 8'(step_size(ch_pstep[c]) - 9'd1);
              p = ch_per[c];
              if (ch_pstep[c][7]) p = (p > PERIOD_STEP) ? p - PERIOD_STEP : 0;
              else                p = p + PERIOD_STEP;
              // clamp only on a ramp step, never on the initial period
              if (p < PERIOD_MIN) p = PERIOD_MIN;
              if (p > PERIOD_MAX) p = PERIOD_MAX;
              ch_per[c] = 21'(p);
              add_command(CMD_SET_PER, c, '0, '0, 21'(p), 1'b0, 1'b0);
            end else begin
              ch_pcnt[c] = ch_pcnt[c] - 8'd1;
            end
          end
        end
      end
      ACT_STOP: begin
        live_requests++;
        add_command(CMD_HALT_ALL, 0, '0, '0, '0, 1'b0, 1'b0);
        for (int i = 0; i < CHANNELS; i++) clear_channel(i);
      end
      default: ;
    endcase
    if (new_cmds.size() != 0) begin
      tail = new_cmds.pop_back();
      tail.last = 1'b1;
      new_cmds.push_back(tail);
    end
    while (new_cmds.size() != 0) pending_cmds.push_back(new_cmds.pop_front());
  endfunction

  // ---------------------------------------------------------------------------
  // Request builders
  // ---------------------------------------------------------------------------
  function automatic sce_req_t start_req(input logic [11:0] mask, input logic [7:0] id,
                                         input bit loaded, input logic [6:0] vol,
                                         input logic [12:0] per, input bit loop_flag,
                                         input logic [7:0] dur, input logic [7:0] vs,
                                         input logic [7:0] ps);
    sce_req_t r;
    r = '0;
    r.action        = ACT_START;
    r.playing_mask  = mask;
    r.effect_id     = id;
    r.sample_loaded = loaded;
    r.volume        = vol;
    r.period        = per;
    r.looping       = loop_flag;
    r.duration      = dur;
    r.vol_step      = vs;
    r.pitch_step    = ps;
    return r;
  endfunction

  function automatic sce_req_t tick_req(input logic [11:0] play, input logic [11:0] exh);
    sce_req_t r;
    r = '0;
    r.action         = ACT_TICK;
    r.playing_mask   = play;
    r.exhausted_mask = exh;
    return r;
  endfunction

  function automatic sce_req_t stop_req();
    sce_req_t r;
    r = '0;
    r.action = ACT_STOP;
    return r;
  endfunction

  // Mostly small ramps so that counters reload often; sometimes off or full range
  function automatic logic [7:0] ramp_step();
    int k;
    k = $urandom_range(0, 3);
    if (k == 0) return 8'd0;
    if (k == 3) return 8'($urandom);
    return 8'($urandom_range(0, 8)) - 8'd4;
  endfunction

  // Well-formed traffic that follows the predicted channel usage, plus some noise
  function automatic sce_req_t rand_request();
    sce_req_t    r;
    int          pick;
    logic [11:0] extra;
    r = '0;
    pick  = $urandom_range(0, 99);
    extra = 12'($urandom) & 12'($urandom) & 12'($urandom);
    r.playing_mask   = ch_busy | extra;
    r.exhausted_mask = ($urandom_range(0, 7) == 0) ? (12'd1 << $urandom_range(0, 11)) : '0;
    r.effect_id      = 8'($urandom_range(0, SAMPLE_COUNT - 1));
    r.sample_loaded  = 1'b1;
    r.volume         = $urandom_range(0, 1) ? 7'($urandom_range(1, 63)) : 7'($urandom);
    case ($urandom_range(0, 3))
      0:       r.period = 13'($urandom);
      1:       r.period = 13'($urandom_range(4000, 4100));
      default: r.period = 13'($urandom_range(40, 120));
    endcase
    r.looping    = ($urandom_range(0, 4) == 0);
    r.duration   = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 10));
    r.vol_step   = ramp_step();
    r.pitch_step = ramp_step();
    if (pick < 45) begin
      r.action = ACT_START;
      if ($urandom_range(0, 9) == 0) r.playing_mask = 12'hFFF;  // force a steal
    end else if (pick < 90) begin
      r.action = ACT_TICK;
      if ($urandom_range(0, 9) == 0) r.playing_mask &= ~(12'd1 << $urandom_range(0, 11));
    end else if (pick < 93) begin
      r.action = ACT_STOP;
    end else begin
      // noise: action, masks, id, load flag and steps over their full width
      r.action         = 2'($urandom);
      r.playing_mask   = 12'($urandom);
      r.exhausted_mask = 12'($urandom);
      r.effect_id      = 8'($urandom);
      r.sample_loaded  = 1'($urandom);
      r.vol_step       = 8'($urandom);
      r.pitch_step     = 8'($urandom);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Shared driving and checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_SHOWN) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input int got, input int want,
                             input int idx);
    if (got != want)
      report_mismatch($sformatf("command %0d %s got %0d want %0d", idx, name, got, want));
  endtask

  // Offers one request and waits for its handshake; valid stays high for the next one
  task automatic send_request(input sce_req_t r);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= r;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    predict_envelope(r);
  endtask

  // Sender pauses until every owed command has come out
  task automatic wait_for_commands();
    int waited;
    waited = 0;
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_cmds.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_cmds.size() != 0) begin
      report_mismatch($sformatf("%0d commands never arrived", pending_cmds.size()));
      pending_cmds.delete();
    end
  endtask

  int cmd_index = 0;

  always @(posedge clk) begin : check_commands
    sce_res_t got;
    sce_res_t want;
    if (rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      got = res_ch.data;
      if (pending_cmds.size() == 0) begin
        report_mismatch($sformatf("unexpected command %0d on channel %0d",
                                  got.command, got.channel));
      end else begin
        want = pending_cmds.pop_front();
        check_field("command",       got.command,       want.command,       cmd_index);
        check_field("channel",       got.channel,       want.channel,       cmd_index);
        check_field("play_id",       got.play_id,       want.play_id,       cmd_index);
        check_field("level",         got.level,         want.level,         cmd_index);
        check_field("period_scaled", got.period_scaled, want.period_scaled, cmd_index);
        check_field("loop_play",     got.loop_play,     want.loop_play,     cmd_index);
        check_field("resample_mode", got.resample_mode, want.resample_mode, cmd_index);
        check_field("last",          got.last,          want.last,          cmd_index);
      end
      cmd_index++;
    end
  end

  // Receiver: random stalls, or one long hold-off counted here when asked
  initial begin : drive_result_ready
    int n;
    res_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_output) begin
        res_ch.ready <= 1'b0;
        for (n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
        hold_output = 1'b0;
        res_ch.ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        res_ch.ready <= 1'b1;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Allocation, saturation, stealing, ignored requests and stop-all
  task automatic test_directed_starts();
    sce_req_t r;
    send_request(stop_req());                                   // nothing active yet
    send_request(start_req(12'h000, 8'd0, 1'b1, 7'd0, 13'd0, 1'b0, 8'd0, 8'd0, 8'd0));
    // top of every field: level saturates, -128 volume ramp, resampled looping play
    send_request(start_req(12'h001, 8'd127, 1'b1, 7'd127, 13'd8191, 1'b1, 8'd255,
                           8'h80, 8'h7F));
    send_request(start_req(12'h000, 8'd128, 1'b1, 7'd10, 13'd100, 1'b0, 8'd3, 8'd1, 8'd1));
    send_request(start_req(12'h000, 8'd255, 1'b1, 7'd10, 13'd100, 1'b0, 8'd3, 8'd1, 8'd1));
    send_request(start_req(12'h000, 8'd3, 1'b0, 7'd10, 13'd100, 1'b0, 8'd3, 8'd1, 8'd1));
    r = tick_req(12'hFFF, 12'hFFF);
    r.action = ACT_UNKNOWN;
    send_request(r);
    // every channel busy: channel 0 is taken over without a halt
    send_request(start_req(12'hFFF, 8'd5, 1'b1, 7'd40, 13'd100, 1'b0, 8'd3, 8'd1, 8'hFF));
    send_request(start_req(12'h7FF, 8'd9, 1'b1, 7'd64, 13'd300, 1'b0, 8'd0, 8'd2, 8'd0));
    send_request(stop_req());
    wait_for_commands();
  endtask

  // Tick walk: ramps, bounds, clamps, expiry, exhaustion and silent release
  task automatic test_directed_ticks();
    // fade out from level 2, pitch ramp into the lower clamp
    send_request(start_req(12'h000, 8'd1, 1'b1, 7'd1, 13'd50, 1'b0, 8'd0, 8'hFF, 8'hFF));
    // fade in towards full scale, pitch ramp into the upper clamp
    send_request(start_req(12'h001, 8'd2, 1'b1, 7'd60, 13'd4096, 1'b0, 8'd0, 8'd1, 8'd1));
    // one-tick duration
    send_request(start_req(12'h003, 8'd3, 1'b1, 7'd20, 13'd200, 1'b0, 8'd1, 8'd0, 8'd0));
    // pitch ramp that will see its data exhausted
    send_request(start_req(12'h007, 8'd4, 1'b1, 7'd20, 13'd200, 1'b0, 8'd0, 8'd0, 8'd3));
    // looping sample: its duration is disregarded
    send_request(start_req(12'h00F, 8'd6, 1'b1, 7'd30, 13'd150, 1'b1, 8'd5, 8'd0, 8'd0));
    send_request(tick_req(12'h01F, 12'h000));
    send_request(tick_req(12'h01F, 12'h000));
    send_request(tick_req(12'h01F, 12'h008));
    send_request(tick_req(12'h01F, 12'h000));
    send_request(tick_req(12'h00F, 12'h000));  // mixer finished channel 4
    send_request(tick_req(12'hFFF, 12'hFFF));
    send_request(stop_req());
    wait_for_commands();
  endtask

  task automatic test_random_traffic(input int count);
    int first;
    first = live_requests;
    while (live_requests - first < count) begin
      // quiet stretch every fourth block of requests
      idle_on = ((live_requests / 25) % 4) != 3;
      send_request(rand_request());
      if ($urandom_range(0, 39) == 0) wait_for_commands();
    end
    idle_on = 1'b1;
    wait_for_commands();
  endtask

  // Receiver holds off while requests keep coming, so the input backs up
  task automatic test_output_stall(input int count);
    int first;
    first = live_requests;
    hold_output = 1'b1;
    while (live_requests - first < count) send_request(rand_request());
    req_ch.valid <= 1'b0;
    while (hold_output) @(posedge clk);
    wait_for_commands();
  endtask

  // Back-to-back requests, both sides always ready
  task automatic test_streaming(input int count);
    int first;
    idle_on = 1'b0;
    first = live_requests;
    while (live_requests - first < count) send_request(rand_request());
    wait_for_commands();
  endtask

  initial begin
    req_ch.valid <= 1'b0;
    req_ch.data  <= '0;
    rst_n        <= 1'b0;
    mismatches    = 0;
    live_requests = 0;
    idle_on       = 1'b1;
    hold_output   = 1'b0;
    ch_busy       = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      ch_ticks[i] = '0;
      ch_lvl[i]   = '0;
      ch_vstep[i] = '0;
      ch_vcnt[i]  = '0;
      ch_pstep[i] = '0;
      ch_pcnt[i]  = '0;
      ch_per[i]   = '0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_starts();
    test_directed_ticks();
    test_random_traffic(100);
    test_output_stall(24);
    test_streaming(30);

    wait_for_commands();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #5000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
